[hdl/tdmm_pkg.sv]
// Shared types and constants of the table-driven Mealy machine engine.
// Holds the operation, status and register index codes and the default sizes.
// No dependencies.
package tdmm_pkg;

	// Default sizes of the transition table and of the output word.
	localparam int MAX_STATES_DEF  = 64;
	localparam int MAX_SYMBOLS_DEF = 16;
	localparam int OUT_BITS_DEF    = 8;

	// Fixed field widths.
	localparam int STATE_W = 6;
	localparam int SNEXT_W = 7;
	localparam int SYM_W   = 4;
	localparam int EOUT_W  = 9;
	localparam int ENTRY_W = SNEXT_W + EOUT_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INITIAL_STATE = 2'd0,
		CFG_ALPHABET_SIZE = 2'd1,
		CFG_STATE_COUNT   = 2'd2
	} cfg_idx_t;

	// Operation carried by an input word.
	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_RUN  = 1'b1
	} func_t;

	// Status reported with each result word.
	typedef enum logic [1:0] {
		ST_STEP = 2'd0,
		ST_STOP = 2'd1,
		ST_LOAD = 2'd2
	} status_t;

	// Reset values of the configuration registers.
	localparam logic [5:0] INIT_STATE_RST  = 6'd0;
	localparam logic [4:0] ALPHA_SIZE_RST  = 5'd2;
	localparam logic [6:0] STATE_COUNT_RST = 7'd64;

	// The "none" code of a stored next state.
	localparam logic [SNEXT_W-1:0] STATE_NONE = '1;

endpackage

[hdl/tdmm_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the transition table. No dependencies.
module tdmm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, and a read port whose data holds until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/table_driven_mealy_machine.sv]
// Top level of the table-driven Mealy machine engine.
// Depends on tdmm_pkg for codes and defaults and on tdmm_ram for the table.
//
// Usage: the input channel (in_valid, in_stall) moves one word per handshake.
// A load word (func = 0) writes one next-state/output entry of the table; a run
// word (func = 1) feeds one symbol, first_sym restarting at initial_state. The
// output channel (out_valid, out_stall) returns exactly one result word per
// input word, in order. Configuration is written through cfg_we/cfg_idx/
// cfg_data while the engine is idle.
// A result passes through the read stage and is then loaded into the output register,
// from which the receiver takes it. A new word is accepted only once the previous
// word has left the read stage, as set by the table read: each
// symbol reads the table entry addressed by the state the previous symbol
// produced, and the single read port is registered.
// The stage behind the output register lets a new word be accepted while a
// finished result still waits; when out_stall holds, that stage fills and
// in_stall rises until the output register is taken.
// Reset clears the valid bits, the current state and the halt flag and loads
// the configuration defaults. The table itself is not cleared: each entry must
// be loaded before a run reads it.
module table_driven_mealy_machine #(
	parameter int MAX_STATES  = tdmm_pkg::MAX_STATES_DEF,
	parameter int MAX_SYMBOLS = tdmm_pkg::MAX_SYMBOLS_DEF,
	parameter int OUT_BITS    = tdmm_pkg::OUT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [tdmm_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [tdmm_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Input channel.
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             func,
	input  logic [5:0]                       row_state,
	input  logic [3:0]                       sym,
	input  logic signed [6:0]                entry_next,
	input  logic signed [8:0]                entry_out,
	input  logic                             first_sym,
	// Output channel.
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [5:0]                       from_state,
	output logic signed [6:0]                to_state,
	output logic [OUT_BITS-1:0]              out_val,
	output logic [1:0]                       status
);

	import tdmm_pkg::*;

	localparam int TABLE_DEPTH = MAX_STATES * MAX_SYMBOLS;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);

	// Configuration registers.
	logic [5:0] init_q;
	logic [4:0] alpha_q;
	logic [6:0] count_q;

	// Machine state.
	logic [6:0] cur_q;
	logic       halted_q;

	// Table-read stage.
	logic                s1_v;
	logic                run_s1;
	logic                look_s1;
	logic [6:0]          cur_s1;
	logic [5:0]          from_s1;
	logic [6:0]          to_s1;
	logic [OUT_BITS-1:0] val_s1;
	status_t             st_s1;

	// Output register.
	logic                out_v_q;
	logic [5:0]          from_q;
	logic [6:0]          to_q;
	logic [OUT_BITS-1:0] val_q;
	status_t             st_q;

	// Front-end signals.
	logic                in_acc;
	logic                is_load;
	logic [6:0]          cur_eff;
	logic                halt_eff;
	logic                stop0;
	logic                load_ok;
	logic [5:0]          row_sel;
	logic [31:0]         addr_wide;
	logic [ADDR_W-1:0]   addr;
	logic                ram_we;
	logic                ram_re;
	logic [ENTRY_W-1:0]  ram_rdata;
	logic [31:0]         load_val_wide;
	logic [5:0]          from_d;
	logic [6:0]          to_d;
	logic [OUT_BITS-1:0] val_d;
	status_t             st_d;

	// Back-end signals.
	logic                s1_go;
	logic [EOUT_W-1:0]   rd_out;
	logic [SNEXT_W-1:0]  rd_next;
	logic [31:0]         step_val_wide;
	logic [5:0]          res_from;
	logic [6:0]          res_to;
	logic [OUT_BITS-1:0] res_val;
	status_t             res_st;
	logic [6:0]          cur_d;
	logic                halt_d;

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= INIT_STATE_RST;
			alpha_q <= ALPHA_SIZE_RST;
			count_q <= STATE_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_INITIAL_STATE: init_q  <= cfg_data[5:0];
				CFG_ALPHABET_SIZE: alpha_q <= cfg_data[4:0];
				CFG_STATE_COUNT:   count_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// One word in flight in the read stage at a time.
	assign in_stall = s1_v;
	assign in_acc   = in_valid && !in_stall;
	assign is_load  = (func == FUNC_LOAD);

	// Effective state for a run word; a first symbol restarts the string.
	always_comb begin
		cur_eff  = first_sym ? {1'b0, init_q} : cur_q;
		halt_eff = first_sym ? 1'b0 : halted_q;
		stop0    = halt_eff || cur_eff[6] || (cur_eff >= count_q)
			|| (32'(cur_eff[5:0]) >= 32'(MAX_STATES))
			|| ({1'b0, sym} >= alpha_q) || (32'(sym) >= 32'(MAX_SYMBOLS));
		load_ok  = (32'(row_state) < 32'(MAX_STATES)) && (32'(sym) < 32'(MAX_SYMBOLS));
	end

	// Table address: row times the column count plus the symbol.
	always_comb begin
		row_sel   = is_load ? row_state : cur_eff[5:0];
		addr_wide = 32'(row_sel) * 32'(MAX_SYMBOLS) + 32'(sym);
		addr      = addr_wide[ADDR_W-1:0];
	end

	assign ram_we = in_acc && is_load && load_ok;
	assign ram_re = in_acc && !is_load && !stop0;

	tdmm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata ({entry_next, entry_out}),
		.re    (ram_re),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	// Result prepared at accept for loads and for symbols that stop up front.
	always_comb begin
		load_val_wide = entry_out[8] ? 32'd0 : {24'd0, entry_out[7:0]};
		if (is_load) begin
			from_d = row_state;
			to_d   = entry_next;
			val_d  = load_val_wide[OUT_BITS-1:0];
			st_d   = load_ok ? ST_LOAD : ST_STOP;
		end else begin
			from_d = cur_eff[6] ? 6'd0 : cur_eff[5:0];
			to_d   = cur_eff;
			val_d  = '0;
			st_d   = ST_STOP;
		end
	end

	// Read-stage control.
	assign s1_go = s1_v && (!out_v_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (in_acc) begin
			s1_v <= 1'b1;
		end else if (s1_go) begin
			s1_v <= 1'b0;
		end
	end

	// Read-stage payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			run_s1  <= !is_load;
			look_s1 <= !is_load && !stop0;
			cur_s1  <= cur_eff;
			from_s1 <= from_d;
			to_s1   <= to_d;
			val_s1  <= val_d;
			st_s1   <= st_d;
		end
	end

	// Finish a run word from the table entry, and the next machine state.
	always_comb begin
		rd_out        = ram_rdata[EOUT_W-1:0];
		rd_next       = ram_rdata[ENTRY_W-1:EOUT_W];
		step_val_wide = {24'd0, rd_out[7:0]};
		res_from      = from_s1;
		res_to        = to_s1;
		res_val       = val_s1;
		res_st        = st_s1;
		cur_d         = cur_q;
		halt_d        = halted_q;
		if (look_s1 && !rd_out[8]) begin
			res_from = cur_s1[5:0];
			res_to   = rd_next[6] ? STATE_NONE : rd_next;
			res_val  = step_val_wide[OUT_BITS-1:0];
			res_st   = ST_STEP;
			cur_d    = res_to;
			halt_d   = !res_to[6] && (res_to >= count_q);
		end else if (look_s1) begin
			// Undefined output entry stops the string.
			res_from = cur_s1[5:0];
			res_to   = cur_s1;
			res_val  = '0;
			res_st   = ST_STOP;
			cur_d    = cur_s1;
			halt_d   = 1'b1;
		end else if (run_s1) begin
			cur_d  = cur_s1;
			halt_d = 1'b1;
		end
	end

	// Machine state changes when a run word leaves the read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			halted_q <= 1'b0;
		end else if (s1_go) begin
			cur_q    <= cur_d;
			halted_q <= halt_d;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_go) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (s1_go) begin
			from_q <= res_from;
			to_q   <= res_to;
			val_q  <= res_val;
			st_q   <= res_st;
		end
	end

	assign out_valid  = out_v_q;
	assign from_state = from_q;
	assign to_state   = to_q;
	assign out_val    = val_q;
	assign status     = st_q;

	// A word leaving the read stage always lands in the output register.
	a_s1_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go |=> out_v_q)
		else $error("read stage drained without filling the output register");

	// A blocked output register keeps the read stage occupied.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v && out_v_q && out_stall |=> s1_v)
		else $error("read stage dropped a word while the output was stalled");

	// A stopped run word leaves the machine halted.
	a_stop_halts: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && run_s1 && (res_st == ST_STOP) |=> halted_q)
		else $error("stopped symbol did not halt the machine");

	// The current state moves only when a word leaves the read stage.
	a_state_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_go |=> $stable(cur_q) && $stable(halted_q))
		else $error("machine state changed outside a read-stage completion");

endmodule

[tb/sv/table_driven_mealy_machine_test.sv]
// Self-checking testbench of the table-driven Mealy machine engine.
// Checks every result word against a local model of the table and the run state.
// Depends on tdmm_pkg and on the table_driven_mealy_machine top level.
module table_driven_mealy_machine_test;
	import tdmm_pkg::*;

	localparam int TBL_COLS    = MAX_SYMBOLS_DEF;
	localparam int TBL_DEPTH   = MAX_STATES_DEF * MAX_SYMBOLS_DEF;
	localparam int QUIET_LIMIT = 5000;

	// One input word and one result word as the engine sees them.
	typedef struct {
		func_t             func;
		logic [5:0]        row;
		logic [3:0]        sym;
		logic signed [6:0] enext;
		logic signed [8:0] eout;
		logic              first;
	} mealy_word_t;

	typedef struct {
		logic [5:0]        from_st;
		logic signed [6:0] to_st;
		logic [7:0]        val;
		status_t           st;
	} transition_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_idx = CFG_INITIAL_STATE;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   func = FUNC_LOAD;
	logic [5:0]             row_state = '0;
	logic [3:0]             sym = '0;
	logic signed [6:0]      entry_next = '0;
	logic signed [8:0]      entry_out = '0;
	logic                   first_sym = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [5:0]             from_state;
	logic signed [6:0]      to_state;
	logic [7:0]             out_val;
	logic [1:0]             status;

	// Local copy of the machine: table, run state and registers.
	logic signed [6:0] next_tbl [0:TBL_DEPTH-1];
	logic signed [8:0] out_tbl [0:TBL_DEPTH-1];
	bit                loaded [0:TBL_DEPTH-1];
	logic signed [6:0] cur_state = '0;
	bit                halted = 1'b0;
	logic [5:0]        init_reg = INIT_STATE_RST;
	logic [4:0]        alpha_reg = ALPHA_SIZE_RST;
	logic [6:0]        count_reg = STATE_COUNT_RST;

	transition_t expected_results [$];
	int          fail_count = 0;
	int          words_sent = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          recv_hold = 0;

	table_driven_mealy_machine u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.row_state  (row_state),
		.sym        (sym),
		.entry_next (entry_next),
		.entry_out  (entry_out),
		.first_sym  (first_sym),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.from_state (from_state),
		.to_state   (to_state),
		.out_val    (out_val),
		.status     (status)
	);

	always #5 clk = ~clk;

	// Apply one word to the local machine and return the transition it reports.
	function automatic transition_t mealy_step(mealy_word_t w);
		transition_t r;
		int          c;
		int          idx;
		if (w.func == FUNC_LOAD) begin
			idx = w.row * TBL_COLS + w.sym;
			next_tbl[idx] = w.enext;
			out_tbl[idx]  = w.eout;
			loaded[idx]   = 1'b1;
			r.from_st = w.row;
			r.to_st   = w.enext;
			r.val     = (w.eout < 0) ? 8'd0 : w.eout[7:0];
			r.st      = ST_LOAD;
			return r;
		end
		if (w.first) begin
			cur_state = {1'b0, init_reg};
			halted    = 1'b0;
		end
		c = cur_state;
		r.from_st = (c < 0) ? 6'd0 : c[5:0];
		r.to_st   = cur_state;
		r.val     = 8'd0;
		r.st      = ST_STOP;
		// Halted, dead, out-of-range state or symbol beyond the alphabet stops the string.
		if (halted || c < 0 || c >= int'(count_reg) || int'(w.sym) >= int'(alpha_reg)) begin
			halted = 1'b1;
			return r;
		end
		idx = c * TBL_COLS + w.sym;
		// An undefined output entry stops the string as well.
		if (out_tbl[idx] < 0) begin
			halted = 1'b1;
			return r;
		end
		cur_state = (next_tbl[idx] < 0) ? STATE_NONE : next_tbl[idx];
		if (cur_state >= 0 && int'(cur_state) >= int'(count_reg))
			halted = 1'b1;
		r.to_st = cur_state;
		r.val   = out_tbl[idx][7:0];
		r.st    = ST_STEP;
		return r;
	endfunction

	// Random next-state entry, mostly inside the states in use.
	function automatic logic signed [6:0] rand_next();
		int r;
		r = $urandom_range(99);
		if (r < 6)
			return STATE_NONE;
		if (r < 14)
			return 7'($urandom_range(63));
		return 7'($urandom_range(int'(count_reg) - 1));
	endfunction

	// Random output entry, now and then undefined.
	function automatic logic signed [8:0] rand_out();
		if ($urandom_range(99) < 6)
			return -9'sd1;
		return 9'($urandom_range(255));
	endfunction

	// Offer one word, wait for its handshake and record the expected result.
	task automatic send_word(input mealy_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= w.func;
		row_state  <= w.row;
		sym        <= w.sym;
		entry_next <= w.enext;
		entry_out  <= w.eout;
		first_sym  <= w.first;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		expected_results.insert(expected_results.size(), mealy_step(w));
		words_sent++;
	endtask

	task automatic send_load(logic [5:0] row, logic [3:0] s, logic signed [6:0] n,
			logic signed [8:0] o);
		mealy_word_t w;
		w.func  = FUNC_LOAD;
		w.row   = row;
		w.sym   = s;
		w.enext = n;
		w.eout  = o;
		w.first = 1'($urandom_range(1));
		send_word(w);
	endtask

	// Run one symbol; an entry the symbol would read is loaded first if still empty.
	task automatic run_symbol(logic [3:0] s, logic f);
		mealy_word_t w;
		int          c;
		bit          h;
		c = f ? int'(init_reg) : int'(cur_state);
		h = f ? 1'b0 : halted;
		if (!h && c >= 0 && c < int'(count_reg) && int'(s) < int'(alpha_reg)) begin
			if (!loaded[c * TBL_COLS + s])
				send_load(c[5:0], s, rand_next(), rand_out());
		end
		w.func  = FUNC_RUN;
		w.row   = 6'($urandom_range(63));
		w.sym   = s;
		w.enext = 7'($urandom_range(127));
		w.eout  = 9'($urandom_range(511));
		w.first = f;
		send_word(w);
	endtask

	// Stop offering words and wait until every result has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all three registers back to back; the engine must be idle.
	task automatic write_regs(logic [5:0] ini, logic [4:0] al, logic [6:0] cnt);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_INITIAL_STATE;
		cfg_data <= {1'b0, ini};
		@(posedge clk);
		cfg_idx  <= CFG_ALPHABET_SIZE;
		cfg_data <= {2'b00, al};
		@(posedge clk);
		cfg_idx  <= CFG_STATE_COUNT;
		cfg_data <= cnt;
		@(posedge clk);
		cfg_we    <= 1'b0;
		init_reg  = ini;
		alpha_reg = al;
		count_reg = cnt;
	endtask

	// Pick a register setting, extremes included, and apply it once idle.
	task automatic reconfigure();
		logic [6:0] cnt;
		logic [4:0] al;
		logic [5:0] ini;
		int         r;
		r = $urandom_range(9);
		cnt = (r < 2) ? 7'd64 : (r == 2) ? 7'd1 : 7'($urandom_range(63, 2));
		r = $urandom_range(9);
		al = (r < 2) ? 5'd16 : (r == 2) ? 5'd1 : 5'($urandom_range(15, 2));
		if ($urandom_range(99) < 85)
			ini = 6'($urandom_range(int'(cnt) - 1));
		else
			ini = 6'($urandom_range(63));
		wait_idle();
		write_regs(ini, al, cnt);
	endtask

	// One string: a restart symbol and then mostly in-alphabet symbols.
	task automatic random_string(int len);
		logic [3:0] s;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 90)
				s = 4'($urandom_range(int'(alpha_reg) - 1));
			else
				s = 4'($urandom_range(15));
			run_symbol(s, i == 0);
		end
	endtask

	// Basic loads and every way a string can step or stop, default registers.
	task automatic test_loads_and_steps();
		send_load(6'd0, 4'd0, 7'sd63, 9'sd255);
		send_load(6'd63, 4'd15, STATE_NONE, -9'sd1);
		send_load(6'd0, 4'd1, 7'sd1, 9'sd0);
		send_load(6'd1, 4'd0, STATE_NONE, 9'sd85);
		send_load(6'd1, 4'd1, 7'sd2, -9'sd1);
		send_load(6'd63, 4'd0, 7'sd0, 9'sd1);
		run_symbol(4'd0, 1'b1);
		run_symbol(4'd0, 1'b0);
		// Symbol beyond the alphabet, then a symbol while halted.
		run_symbol(4'd15, 1'b0);
		run_symbol(4'd0, 1'b0);
		// Step into the dead state, then try to leave it.
		run_symbol(4'd1, 1'b1);
		run_symbol(4'd0, 1'b0);
		run_symbol(4'd0, 1'b0);
		// Undefined output entry.
		run_symbol(4'd1, 1'b1);
		run_symbol(4'd1, 1'b0);
		wait_idle();
	endtask

	// Register extremes: next state past the count, start state past the count.
	task automatic test_config_extremes();
		write_regs(6'd63, 5'd16, 7'd64);
		run_symbol(4'd15, 1'b1);
		run_symbol(4'd0, 1'b1);
		wait_idle();
		write_regs(6'd0, 5'd1, 7'd1);
		run_symbol(4'd0, 1'b1);
		run_symbol(4'd0, 1'b0);
		run_symbol(4'd1, 1'b1);
		wait_idle();
		write_regs(6'd63, 5'd16, 7'd1);
		run_symbol(4'd0, 1'b1);
		wait_idle();
	endtask

	// Receiver holds off for a long stretch while words keep coming.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		reconfigure();
		recv_hold = 300;
		while (recv_hold > 0)
			random_string($urandom_range(8, 2));
		// Sender pauses until every result is back.
		wait_idle();
	endtask

	// Random strings with noise, new register setting every few dozen words.
	task automatic test_random(int s_pct, int r_pct, int n_words);
		int phase_start;
		int chunk_start;
		int r;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		phase_start = words_sent;
		while (words_sent - phase_start < n_words) begin
			reconfigure();
			chunk_start = words_sent;
			while (words_sent - chunk_start < 60 && words_sent - phase_start < n_words) begin
				r = $urandom_range(99);
				if (r < 10)
					send_load(6'($urandom_range(63)), 4'($urandom_range(15)),
						7'(int'($urandom_range(64)) - 1), 9'(int'($urandom_range(256)) - 1));
				else if (r < 15)
					run_symbol(4'($urandom_range(15)), 1'b0);
				else
					random_string($urandom_range(12, 1));
			end
		end
		wait_idle();
	endtask

	// Receiver: random stalls, or a counted hold-off when one is requested.
	always @(posedge clk) begin
		if (recv_hold > 0) begin
			out_stall <= 1'b1;
			recv_hold--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Compare each accepted result word with the oldest expectation.
	always @(posedge clk) begin : check_results
		transition_t exp_r;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_results.size() == 0) begin
				$error("result word with no expectation waiting");
				fail_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (from_state !== exp_r.from_st) begin
					$error("from_state: expected %0d, actual %0d", exp_r.from_st, from_state);
					fail_count++;
				end
				if (to_state !== exp_r.to_st) begin
					$error("to_state: expected %0d, actual %0d", exp_r.to_st, to_state);
					fail_count++;
				end
				if (out_val !== exp_r.val) begin
					$error("out_val: expected %0d, actual %0d", exp_r.val, out_val);
					fail_count++;
				end
				if (status !== exp_r.st) begin
					$error("status: expected %0d, actual %0d", exp_r.st, status);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: too long without any handshake ends the run.
	always @(posedge clk) begin : watchdog
		int quiet_cycles;
		if (!arst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 37;
		recv_idle_pct = 71;
		test_loads_and_steps();
		test_config_extremes();
		test_random(37, 71, 170);
		test_random(71, 37, 170);
		test_backpressure();
		test_random(0, 0, 170);
		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
